// ===== design/ktvd_pkg.sv =====
package ktvd_pkg;

    localparam int IDX_W      = 4;
    localparam int WORD_W     = 16;
    localparam int LEN_W      = 19;
    localparam int OFS_W      = 32;
    localparam int CFG_W      = 32;
    localparam int NUM_TASKS_DEF = 16;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 48;

    localparam logic [WORD_W-1:0] FC_LOADBIN   = 16'h0100;
    localparam logic [WORD_W-1:0] FC_LOAD      = 16'h0110;
    localparam logic [WORD_W-1:0] FC_SAVE      = 16'h0111;
    localparam logic [WORD_W-1:0] FC_NEXT      = 16'h0112;
    localparam logic [WORD_W-1:0] FC_MOVE      = 16'h0113;
    localparam logic [WORD_W-1:0] FC_GETUTF    = 16'h0601;
    localparam logic [WORD_W-1:0] FC_SEND      = 16'h0700;
    localparam logic [WORD_W-1:0] FC_LISTUSERS = 16'h0710;

    localparam logic [WORD_W-1:0] STAT_WAITING = 16'h0001;
    localparam logic [WORD_W-1:0] RAM_LOW      = 16'h0040;
    localparam logic [LEN_W-1:0]  LEN_MAX      = 19'h0FFC0;
    localparam logic [16:0]       RAM_TOP      = 17'h10000;
    localparam logic [LEN_W-1:0]  UID_LEN      = 19'd8;

    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_DISPATCH = 2'd1,
        ACT_FAULT    = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        HND_LOADBIN   = 3'd0,
        HND_LOAD      = 3'd1,
        HND_SAVE      = 3'd2,
        HND_NEXT      = 3'd3,
        HND_MOVE      = 3'd4,
        HND_GETUTF    = 3'd5,
        HND_SEND      = 3'd6,
        HND_LISTUSERS = 3'd7
    } t_handler;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  task_index;
        logic [WORD_W-1:0] status_word;
        logic [WORD_W-1:0] function_code;
        logic [WORD_W-1:0] param_one;
        logic [WORD_W-1:0] param_two;
        logic [WORD_W-1:0] param_three;
        logic [WORD_W-1:0] param_four;
        logic [WORD_W-1:0] param_five;
        logic [WORD_W-1:0] param_six;
    } t_item;

    typedef struct packed {
        t_action          action;
        t_handler         handler;
        logic [IDX_W-1:0] out_task_index;
        logic [OFS_W-1:0] file_offset;
    } t_result;

    // true when the offset/length pair falls outside data RAM
    function automatic logic range_bad(input logic [WORD_W-1:0] off,
                                       input logic [LEN_W-1:0] len);
        logic [16:0] lim;
        lim = RAM_TOP - len[16:0];
        return (len > LEN_MAX) || (off < RAM_LOW) || ({1'b0, off} > lim);
    endfunction

endpackage

// ===== design/ktvd_eval.sv =====
module ktvd_eval #(
    parameter int NUM_TASKS = ktvd_pkg::NUM_TASKS_DEF
) (
    input  ktvd_pkg::t_item                 i_item,
    input  logic [NUM_TASKS-1:0]            i_flags,
    input  logic [ktvd_pkg::CFG_W-1:0]      i_data_area_size,
    output ktvd_pkg::t_result               o_result,
    output logic [NUM_TASKS-1:0]            o_flags
);

    logic [NUM_TASKS-1:0]          sel;
    logic                          in_range;
    logic                          running;
    logic                          bad;
    ktvd_pkg::t_handler            hnd;
    logic                          has_ofs;
    logic [ktvd_pkg::OFS_W-1:0]    foff;
    logic [ktvd_pkg::OFS_W:0]      lb_end;
    logic [ktvd_pkg::LEN_W-1:0]    l_p2;
    logic [ktvd_pkg::LEN_W-1:0]    l_p4;
    logic [ktvd_pkg::LEN_W-1:0]    l_p6;
    logic [ktvd_pkg::LEN_W-1:0]    l_half;
    logic [ktvd_pkg::LEN_W-1:0]    l_x8;
    logic [ktvd_pkg::WORD_W:0]     p2_inc;

    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            sel[i] = (i_item.task_index == ktvd_pkg::IDX_W'(i));
        end
    end

    assign in_range = |sel;
    assign running  = |(i_flags & sel);

    assign foff   = {i_item.param_three, i_item.param_four};
    assign lb_end = {1'b0, foff} + {17'd0, i_item.param_two};
    assign p2_inc = {1'b0, i_item.param_two} + 17'd1;
    assign l_p2   = {3'd0, i_item.param_two};
    assign l_p4   = {3'd0, i_item.param_four};
    assign l_p6   = {3'd0, i_item.param_six};
    assign l_half = {3'd0, p2_inc[16:1]};
    assign l_x8   = {i_item.param_two, 3'd0};

    always_comb begin
        hnd     = ktvd_pkg::HND_LOADBIN;
        has_ofs = 1'b0;
        bad     = 1'b0;
        case (i_item.function_code)
            ktvd_pkg::FC_LOADBIN: begin
                has_ofs = 1'b1;
                bad = ktvd_pkg::range_bad(i_item.param_one, l_p2) ||
                      (lb_end > {1'b0, i_data_area_size});
            end
            ktvd_pkg::FC_LOAD: begin
                hnd = ktvd_pkg::HND_LOAD;
                has_ofs = 1'b1;
                bad = ktvd_pkg::range_bad(i_item.param_one, l_half) ||
                      ktvd_pkg::range_bad(i_item.param_five, l_p6);
            end
            ktvd_pkg::FC_SAVE: begin
                hnd = ktvd_pkg::HND_SAVE;
                has_ofs = 1'b1;
                bad = ktvd_pkg::range_bad(i_item.param_one, l_half) ||
                      ktvd_pkg::range_bad(i_item.param_five, l_p6);
            end
            ktvd_pkg::FC_NEXT: begin
                hnd = ktvd_pkg::HND_NEXT;
                bad = ktvd_pkg::range_bad(i_item.param_one, l_p2);
            end
            ktvd_pkg::FC_MOVE: begin
                hnd = ktvd_pkg::HND_MOVE;
                bad = ktvd_pkg::range_bad(i_item.param_one, l_p2) ||
                      ktvd_pkg::range_bad(i_item.param_three, l_p4);
            end
            ktvd_pkg::FC_GETUTF: begin
                hnd = ktvd_pkg::HND_GETUTF;
                bad = ktvd_pkg::range_bad(i_item.param_one, l_p2) ||
                      ktvd_pkg::range_bad(i_item.param_three, l_p4) ||
                      ktvd_pkg::range_bad(i_item.param_five, ktvd_pkg::UID_LEN);
            end
            ktvd_pkg::FC_SEND: begin
                hnd = ktvd_pkg::HND_SEND;
                bad = ktvd_pkg::range_bad(i_item.param_one, l_p2) ||
                      ktvd_pkg::range_bad(i_item.param_three, ktvd_pkg::UID_LEN);
            end
            ktvd_pkg::FC_LISTUSERS: begin
                hnd = ktvd_pkg::HND_LISTUSERS;
                bad = ktvd_pkg::range_bad(i_item.param_one, l_x8) ||
                      ktvd_pkg::range_bad(i_item.param_three, ktvd_pkg::UID_LEN);
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_flags                 = i_flags;
        o_result.action         = ktvd_pkg::ACT_NONE;
        o_result.handler        = ktvd_pkg::HND_LOADBIN;
        o_result.out_task_index = i_item.task_index;
        o_result.file_offset    = '0;
        if (in_range) begin
            if (i_item.cmd == ktvd_pkg::CMD_CLEAR) begin
                o_flags = i_flags & ~sel;
            end else if (i_item.status_word == ktvd_pkg::STAT_WAITING && !running) begin
                o_flags = i_flags | sel;
                if (bad) begin
                    o_result.action = ktvd_pkg::ACT_FAULT;
                end else begin
                    o_result.action  = ktvd_pkg::ACT_DISPATCH;
                    o_result.handler = hnd;
                    if (has_ofs) begin
                        o_result.file_offset = foff;
                    end
                end
            end
        end
    end

endmodule

// ===== design/kernel_task_validate_dispatch.sv =====
// Kernel task validate and dispatch.
// Slave stream: one transaction per task command. tuser carries cmd (0 offer a
// descriptor, 1 clear the task's running flag); tdata carries the descriptor.
// Master stream: exactly one result transaction per input transaction, in order,
// giving the action (none, dispatch, fault), handler kind, task index and, for
// load-binary/load/save, the 32-bit file offset.
// Configuration: i_cfg_we writes i_cfg_wdata into the data area size register;
// write it only while no transaction is in flight.
// From input acceptance to a valid result there is one input register, then the
// decode and range checks feed the result register, where the running flags are
// also updated. Throughput is one transaction per cycle while the receiver keeps
// tready high; the flag update lands at the edge that loads the result register,
// so back-to-back commands on one task see each other in order.
// Reset clears the running flags, the data area size and both stage valids.
// When the receiver holds tready low the result is held and the input register
// keeps one more transaction, after which s_axis tready drops.
module kernel_task_validate_dispatch #(
    parameter int NUM_TASKS = ktvd_pkg::NUM_TASKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // task_index[3:0], status_word[19:4], function_code[35:20], param_one[51:36],
    // param_two[67:52], param_three[83:68], param_four[99:84],
    // param_five[115:100], param_six[131:116], zero pad[135:132]
    input  logic [ktvd_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // cmd[0]
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // action[1:0], handler[4:2], out_task_index[8:5], file_offset[40:9],
    // zero pad[47:41]
    output logic [ktvd_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [ktvd_pkg::CFG_W-1:0]        i_cfg_wdata
);

    logic                          r_in_valid;
    ktvd_pkg::t_item               r_in;
    logic                          r_out_valid;
    ktvd_pkg::t_result             r_out;
    logic [NUM_TASKS-1:0]          r_flags;
    logic [ktvd_pkg::CFG_W-1:0]    r_data_area_size;

    logic                          out_free;
    logic                          advance;
    logic                          s_fire;
    ktvd_pkg::t_result             n_out;
    logic [NUM_TASKS-1:0]          n_flags;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    ktvd_eval #(
        .NUM_TASKS (NUM_TASKS)
    ) u_eval (
        .i_item           (r_in),
        .i_flags          (r_flags),
        .i_data_area_size (r_data_area_size),
        .o_result         (n_out),
        .o_flags          (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_flags          <= '0;
            r_data_area_size <= '0;
        end else begin
            if (i_cfg_we) begin
                r_data_area_size <= i_cfg_wdata;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            // commit the flag update only when the item moves to the result stage
            if (advance) begin
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in.cmd           <= i_s_axis_tuser;
            r_in.task_index    <= i_s_axis_tdata[3:0];
            r_in.status_word   <= i_s_axis_tdata[19:4];
            r_in.function_code <= i_s_axis_tdata[35:20];
            r_in.param_one     <= i_s_axis_tdata[51:36];
            r_in.param_two     <= i_s_axis_tdata[67:52];
            r_in.param_three   <= i_s_axis_tdata[83:68];
            r_in.param_four    <= i_s_axis_tdata[99:84];
            r_in.param_five    <= i_s_axis_tdata[115:100];
            r_in.param_six     <= i_s_axis_tdata[131:116];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out.file_offset, r_out.out_task_index,
                              r_out.handler, r_out.action};

    a_no_reserved_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.action != 2'd3))
        else $error("reserved action code in result");

    a_idle_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action != ktvd_pkg::ACT_DISPATCH) |->
        (r_out.handler == ktvd_pkg::HND_LOADBIN && r_out.file_offset == '0))
        else $error("non-dispatch result carries handler or offset");

    a_clear_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.cmd == ktvd_pkg::CMD_CLEAR && r_in.task_index == '0)
        |=> !r_flags[0])
        else $error("clear command left task 0 running");

    a_sched_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out.action != ktvd_pkg::ACT_NONE) |=> (|r_flags))
        else $error("scheduled task has no running flag");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance && !$past(!i_rst_n)) |=> $stable(r_flags))
        else $error("running flags changed without an item");

endmodule

// ===== verif/kernel_task_validate_dispatch_tb.sv =====
module kernel_task_validate_dispatch_tb;
    import ktvd_pkg::*;

    localparam int NUM_TASKS   = NUM_TASKS_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTS  = 50;

    localparam logic [WORD_W-1:0] FC_LIST [8] = '{FC_LOADBIN, FC_LOAD, FC_SAVE, FC_NEXT,
                                                  FC_MOVE, FC_GETUTF, FC_SEND, FC_LISTUSERS};

    // how a parameter word turns into the length that gets range checked
    typedef enum int {SPAN_PLAIN, SPAN_HALF, SPAN_OCT, SPAN_FIXED} t_span;

    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    t_item                held_item = '0;
    t_item                task_cmd_q [$];
    t_result              outcome_q [$];
    t_result              want;

    logic [NUM_TASKS-1:0] busy_tasks      = '0;
    logic [31:0]          data_area_bound = '0;

    int                   gap_left     = 0;
    int                   burst_left   = 0;
    int unsigned          stall_cyc    = 0;
    int                   stall_mode   = 0;
    int                   quiet_cycles = 0;
    int                   errors       = 0;
    int                   n_cmds       = 0;
    int                   n_dispatch   = 0;
    int                   n_fault      = 0;
    int                   n_sizes      = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // tdata: task_index, status_word, function_code, param_one..param_six, zero pad
    assign s_tdata = {4'b0000, held_item.param_six, held_item.param_five,
                      held_item.param_four, held_item.param_three, held_item.param_two,
                      held_item.param_one, held_item.function_code, held_item.status_word,
                      held_item.task_index};
    assign s_tuser = held_item.cmd;

    kernel_task_validate_dispatch dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    function automatic logic span_outside(input int unsigned ofs, input int unsigned len);
        return (len > LEN_MAX) || (ofs < RAM_LOW) || (ofs > RAM_TOP - len);
    endfunction

    // expected result of one task command; updates the running flags
    function automatic t_result dispatch_outcome(input t_item it);
        t_result     r;
        int unsigned p1, p2, p3, p4, p5, p6;
        logic [31:0] fofs;
        logic        bad;
        logic        keep_ofs;
        t_handler    hnd;
        p1 = 32'(it.param_one);
        p2 = 32'(it.param_two);
        p3 = 32'(it.param_three);
        p4 = 32'(it.param_four);
        p5 = 32'(it.param_five);
        p6 = 32'(it.param_six);
        fofs = {it.param_three, it.param_four};
        r.action = ACT_NONE;
        r.handler = HND_LOADBIN;
        r.out_task_index = it.task_index;
        r.file_offset = '0;
        if (it.task_index < NUM_TASKS) begin
            if (it.cmd == CMD_CLEAR) begin
                busy_tasks[it.task_index] = 1'b0;
            end else if (it.status_word == STAT_WAITING && !busy_tasks[it.task_index]) begin
                busy_tasks[it.task_index] = 1'b1;
                bad = 1'b0;
                keep_ofs = 1'b0;
                hnd = HND_LOADBIN;
                case (it.function_code)
                    FC_LOADBIN: begin
                        bad = span_outside(p1, p2) ||
                              (64'(fofs) + 64'(p2) > 64'(data_area_bound));
                        keep_ofs = 1'b1;
                    end
                    FC_LOAD, FC_SAVE: begin
                        hnd = (it.function_code == FC_LOAD) ? HND_LOAD : HND_SAVE;
                        bad = span_outside(p1, (p2 + 1) >> 1) || span_outside(p5, p6);
                        keep_ofs = 1'b1;
                    end
                    FC_NEXT: begin
                        hnd = HND_NEXT;
                        bad = span_outside(p1, p2);
                    end
                    FC_MOVE: begin
                        hnd = HND_MOVE;
                        bad = span_outside(p1, p2) || span_outside(p3, p4);
                    end
                    FC_GETUTF: begin
                        hnd = HND_GETUTF;
                        bad = span_outside(p1, p2) || span_outside(p3, p4) ||
                              span_outside(p5, UID_LEN);
                    end
                    FC_SEND: begin
                        hnd = HND_SEND;
                        bad = span_outside(p1, p2) || span_outside(p3, UID_LEN);
                    end
                    FC_LISTUSERS: begin
                        hnd = HND_LISTUSERS;
                        bad = span_outside(p1, p2 << 3) || span_outside(p3, UID_LEN);
                    end
                    default: begin
                        bad = 1'b1;
                    end
                endcase
                if (bad) begin
                    r.action = ACT_FAULT;
                end else begin
                    r.action = ACT_DISPATCH;
                    r.handler = hnd;
                    r.file_offset = keep_ofs ? fofs : '0;
                end
            end
        end
        return r;
    endfunction

    function automatic t_item mk(input logic cmd, input logic [3:0] idx,
                                 input logic [15:0] stat, input logic [15:0] fc,
                                 input logic [15:0] p1, input logic [15:0] p2,
                                 input logic [15:0] p3, input logic [15:0] p4,
                                 input logic [15:0] p5, input logic [15:0] p6);
        t_item it;
        it.cmd = cmd;
        it.task_index = idx;
        it.status_word = stat;
        it.function_code = fc;
        it.param_one = p1;
        it.param_two = p2;
        it.param_three = p3;
        it.param_four = p4;
        it.param_five = p5;
        it.param_six = p6;
        return it;
    endfunction

    function automatic t_item random_item();
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_item)-1:0];
    endfunction

    function automatic logic [15:0] edge_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'h003F;
            2: return 16'h0040;
            3: return 16'hFFC0;
            4: return 16'hFFC1;
            5: return 16'hFFFF;
            6: return 16'h0008;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_len(input int unsigned max_len);
        case ($urandom_range(0, 4))
            0: return 0;
            1: return max_len;
            2: return $urandom_range(1, 16);
            default: return $urandom_range(0, max_len);
        endcase
    endfunction

    // {offset, parameter word}, mostly inside data RAM, now and then arbitrary
    function automatic logic [31:0] gen_span(input t_span kind);
        int unsigned len;
        int unsigned prm;
        int unsigned top;
        int unsigned ofs;
        if ($urandom_range(0, 99) < 12) begin
            return {edge_word(), edge_word()};
        end
        case (kind)
            SPAN_HALF: begin
                len = pick_len(32'h8000);
                prm = (len == 0) ? 0 :
                      2 * len - ((len == 32'h8000) ? 1 : $urandom_range(0, 1));
            end
            SPAN_OCT: begin
                prm = pick_len(32'h1FF8);
                len = prm * 8;
            end
            SPAN_FIXED: begin
                len = 32'(UID_LEN);
                prm = $urandom_range(0, 16'hFFFF);
            end
            default: begin
                len = pick_len(32'(LEN_MAX));
                prm = len;
            end
        endcase
        top = (len == 0) ? 32'hFFFF : RAM_TOP - len;
        case ($urandom_range(0, 3))
            0: ofs = 32'(RAM_LOW);
            1: ofs = top;
            default: ofs = $urandom_range(RAM_LOW, top);
        endcase
        return {ofs[15:0], prm[15:0]};
    endfunction

    function automatic t_item random_offer(input logic [3:0] idx);
        t_item       it;
        logic [31:0] span;
        logic [31:0] fofs;
        int unsigned room;
        it = random_item();
        it.cmd = CMD_OFFER;
        it.task_index = idx;
        case ($urandom_range(0, 19))
            0: it.status_word = 16'h0000;
            1: it.status_word = 16'h8000;
            2: it.status_word = edge_word();
            default: it.status_word = STAT_WAITING;
        endcase
        it.function_code = ($urandom_range(0, 15) == 0) ? edge_word() :
                           FC_LIST[$urandom_range(0, 7)];
        case (it.function_code)
            FC_LOADBIN: begin
                {it.param_one, it.param_two} = gen_span(SPAN_PLAIN);
                // mostly fit the data area, sometimes land one past it or wrap
                if ($urandom_range(0, 9) < 7 && data_area_bound >= it.param_two) begin
                    room = data_area_bound - it.param_two;
                    fofs = ($urandom_range(0, 2) == 0) ? room : $urandom_range(0, room);
                end else begin
                    case ($urandom_range(0, 2))
                        0: fofs = 32'hFFFF_FFFF;
                        1: fofs = data_area_bound - it.param_two + 1;
                        default: fofs = $urandom;
                    endcase
                end
                {it.param_three, it.param_four} = fofs;
            end
            FC_LOAD, FC_SAVE: begin
                {it.param_one, it.param_two} = gen_span(SPAN_HALF);
                {it.param_five, it.param_six} = gen_span(SPAN_PLAIN);
            end
            FC_NEXT: begin
                {it.param_one, it.param_two} = gen_span(SPAN_PLAIN);
            end
            FC_MOVE: begin
                {it.param_one, it.param_two} = gen_span(SPAN_PLAIN);
                {it.param_three, it.param_four} = gen_span(SPAN_PLAIN);
            end
            FC_GETUTF: begin
                {it.param_one, it.param_two} = gen_span(SPAN_PLAIN);
                {it.param_three, it.param_four} = gen_span(SPAN_PLAIN);
                span = gen_span(SPAN_FIXED);
                it.param_five = span[31:16];
            end
            FC_SEND, FC_LISTUSERS: begin
                {it.param_one, it.param_two} =
                    gen_span((it.function_code == FC_SEND) ? SPAN_PLAIN : SPAN_OCT);
                span = gen_span(SPAN_FIXED);
                it.param_three = span[31:16];
            end
            default: begin
            end
        endcase
        return it;
    endfunction

    // mostly clear-then-offer pairs on one task, the rest stray commands
    task automatic fill_random(input int n);
        int         count;
        logic [3:0] idx;
        t_item      junk;
        count = 0;
        while (count < n) begin
            idx = 4'($urandom_range(0, NUM_TASKS - 1));
            junk = random_item();
            junk.cmd = CMD_CLEAR;
            junk.task_index = idx;
            if ($urandom_range(0, 3) != 0) begin
                task_cmd_q.push_back(junk);
                task_cmd_q.push_back(random_offer(idx));
                count += 2;
            end else begin
                case ($urandom_range(0, 2))
                    0: task_cmd_q.push_back(random_offer(idx));
                    1: task_cmd_q.push_back(random_item());
                    default: task_cmd_q.push_back(junk);
                endcase
                count += 1;
            end
        end
    endtask

    task automatic drain();
        while (task_cmd_q.size() != 0 || s_valid || outcome_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_area(input logic [31:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        data_area_bound = value;
        n_sizes++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [40:0] got,
                                   input logic [40:0] exp_val);
        if (errors < MAX_PRINTS) begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
        end
        errors++;
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (task_cmd_q.size() != 0) begin
                held_item <= task_cmd_q.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall mode changes now and then
    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        if (stall_cyc % 97 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_cyc % 24) >= 16;
        endcase
    end

    // check results first, then predict for the command accepted at this edge
    always @(posedge i_clk) begin
        if (rst_n && m_valid && m_ready) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[40:0], '0);
            end else begin
                want = outcome_q.pop_front();
                if (m_tdata[1:0] != want.action) begin
                    report_mismatch("action", m_tdata[1:0], want.action);
                end
                if (m_tdata[4:2] != want.handler) begin
                    report_mismatch("handler", m_tdata[4:2], want.handler);
                end
                if (m_tdata[8:5] != want.out_task_index) begin
                    report_mismatch("task index", m_tdata[8:5], want.out_task_index);
                end
                if (m_tdata[40:9] != want.file_offset) begin
                    report_mismatch("file offset", m_tdata[40:9], want.file_offset);
                end
            end
        end
        if (rst_n && s_valid && s_ready) begin
            want = dispatch_outcome(held_item);
            outcome_q.push_back(want);
            n_cmds++;
            if (want.action == ACT_DISPATCH) begin
                n_dispatch++;
            end else if (want.action == ACT_FAULT) begin
                n_fault++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // data area size is still zero from reset
        task_cmd_q.push_back(mk(CMD_OFFER, 0, STAT_WAITING, FC_LOADBIN, 16'h0040, 0, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 0, STAT_WAITING, FC_LOADBIN, 16'h0040, 0, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_CLEAR, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        task_cmd_q.push_back(mk(CMD_OFFER, 0, STAT_WAITING, FC_LOADBIN, 16'h0040, 1, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 1, 16'h0000, FC_NEXT, 16'h0040, 1, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 2, 16'h8000, FC_NEXT, 16'h0040, 1, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 3, 16'hFFFF, FC_NEXT, 16'h0040, 1, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 4, STAT_WAITING, FC_LOAD, 16'hFFFF, 1,
                                16'hFFFF, 16'hFFFF, 16'h0040, 16'hFFC0));
        task_cmd_q.push_back(mk(CMD_OFFER, 5, STAT_WAITING, FC_SAVE, 16'h0040, 16'hFFFF,
                                16'h1234, 16'h5678, 16'h003F, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 6, STAT_WAITING, FC_NEXT, 16'h0040, 16'hFFC0,
                                0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 7, STAT_WAITING, FC_NEXT, 16'h0040, 16'hFFC1,
                                0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 8, STAT_WAITING, FC_MOVE, 16'h8000, 16'h8000,
                                16'h0040, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 9, STAT_WAITING, FC_GETUTF, 16'h0100, 16'h0010,
                                16'h0200, 16'h0020, 16'hFFF8, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 10, STAT_WAITING, FC_GETUTF, 16'h0100, 16'h0010,
                                16'h0200, 16'h0020, 16'hFFF9, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 11, STAT_WAITING, FC_SEND, 16'h0040, 0,
                                16'hFFF8, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 12, STAT_WAITING, FC_LISTUSERS, 16'h0040, 16'h1FF8,
                                16'h0040, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 13, STAT_WAITING, FC_LISTUSERS, 16'h0040, 16'h1FF9,
                                16'h0040, 0, 0, 0));
        // unknown code still marks the task as running
        task_cmd_q.push_back(mk(CMD_OFFER, 14, STAT_WAITING, 16'hFFFF, 16'h0040, 1, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 14, STAT_WAITING, FC_NEXT, 16'h0040, 1, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_CLEAR, 14, 0, 0, 0, 0, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 14, STAT_WAITING, 16'h0000, 16'h0040, 1, 0, 0, 0, 0));
        task_cmd_q.push_back(mk(CMD_OFFER, 15, STAT_WAITING, FC_SEND, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        task_cmd_q.push_back(mk(CMD_CLEAR, 15, STAT_WAITING, FC_NEXT, 16'h0040, 1, 0, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_area(32'hFFFF_FFFF);
                1: write_area(32'h0000_0000);
                2: write_area(32'h0001_0000);
                3: write_area($urandom_range(0, 32'h0002_0000));
                4: write_area($urandom);
                default: write_area(32'hFFFF_FFFF);
            endcase
            @(negedge i_clk);
            fill_random(185);
            drain();
        end

        $display("covered %0d task commands under %0d data area sizes", n_cmds, n_sizes + 1);
        $display("  %0d dispatched, %0d faulted, %0d left alone, %0d mismatches",
                 n_dispatch, n_fault, n_cmds - n_dispatch - n_fault, errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ktvd_pkg.sv
design/ktvd_eval.sv
design/kernel_task_validate_dispatch.sv
verif/kernel_task_validate_dispatch_tb.sv
